@@ design/urlpd_pkg.sv @@
`default_nettype none

package urlpd_pkg;

  // Character codes
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChLowerU  = 8'h75;
  localparam logic [7:0] ChUpperU  = 8'h55;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChQuest   = 8'h3F;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChQuote   = 8'h22;

  // Most words one input byte can cause, and most held bytes of one escape
  localparam int unsigned MaxWords = 6;
  localparam int unsigned MaxHeld  = 5;
  localparam int unsigned CntW     = $clog2(MaxWords + 1);

  // Held bytes of an unfinished escape, in the order they arrived
  typedef struct packed {
    logic [MaxHeld-1:0][7:0] bytes;
    logic [CntW-1:0]         len;
  } flush_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Letters have bit 6 set and low nibble 1..6
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    return {hex_val(hi), hex_val(lo)};
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return c == ChSpace || c == ChQuote || c == ChPercent ||
           c == ChAmp || c == ChQuest || c == ChSlash;
  endfunction

  // List the bytes held for an escape that is being given up
  function automatic flush_t flush_held(input logic [2:0] cnt, input logic is_u,
                                        input logic [7:0] uch, input logic [7:0] h0,
                                        input logic [7:0] h1, input logic [7:0] h2);
    flush_t f;
    f = '0;
    if (cnt >= 3'd1 && cnt <= 3'd5) begin
      f.bytes[0] = ChPercent;
      f.len      = CntW'(1);
      if (is_u) begin
        if (cnt >= 3'd2) begin
          f.bytes[1] = uch;
          f.len      = CntW'(2);
        end
        if (cnt >= 3'd3) begin
          f.bytes[2] = h0;
          f.len      = CntW'(3);
        end
        if (cnt >= 3'd4) begin
          f.bytes[3] = h1;
          f.len      = CntW'(4);
        end
        if (cnt >= 3'd5) begin
          f.bytes[4] = h2;
          f.len      = CntW'(5);
        end
      end else if (cnt >= 3'd2) begin
        f.bytes[1] = h0;
        f.len      = CntW'(2);
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

@@ design/url_percent_decoder.sv @@
`default_nettype none

// URL percent decoder. Takes one string byte per input word and gives the
// decoded bytes as output words, one per cycle while out_stall_i is low. An
// input byte is decoded in the cycle it is accepted; its zero to six result
// words land in a six-entry result buffer that drains one word a cycle when
// not stalled, and the next byte is taken in the same cycle the buffer's last
// word leaves. Plain text flows at one byte per cycle when not stalled; a
// broken escape given back as literal bytes holds off input until they drain.
// The plus-to-space register is written with cfg_we_i and takes effect on the
// next accepted byte; write it only while no string is in progress.
module url_percent_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       string_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            has_byte_o,
  output logic            run_last_o,
  output logic            string_end_o,
  output logic            suspicious_o
);
  import urlpd_pkg::*;

  // Configuration and decoder state
  logic       plus_q;
  logic [2:0] pend_cnt_q, pend_cnt_d;
  logic       pend_u_q, pend_u_d;
  logic [7:0] u_char_q, u_char_d;
  logic [7:0] held_q [3];
  logic [7:0] held_d [3];
  logic       susp_q, susp_d;

  // Result buffer
  logic [7:0]      buf_q [MaxWords];
  logic [CntW-1:0] buf_cnt_q;
  logic            buf_has_q, buf_end_q, buf_sus_q;

  // Decode signals
  logic            in_acc, out_acc;
  logic [7:0]      c;
  logic            brk, put, load;
  logic [7:0]      put_byte;
  logic [7:0]      em [MaxWords];
  logic [CntW-1:0] n;
  flush_t          fl_old, fl_new;
  logic [2:0]      tk_cnt;
  logic            tk_u;
  logic            tk_susp;

  assign out_valid_o = buf_cnt_q != '0;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = out_valid_o && !(buf_cnt_q == CntW'(1) && out_acc);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign out_byte_o   = buf_q[0];
  assign run_last_o   = buf_cnt_q == CntW'(1);
  assign has_byte_o   = buf_has_q;
  assign string_end_o = buf_end_q && run_last_o;
  assign suspicious_o = buf_sus_q && string_end_o;

  assign c      = (plus_q && in_byte_i == ChPlus) ? ChSpace : in_byte_i;
  assign fl_old = flush_held(pend_cnt_q, pend_u_q, u_char_q, held_q[0], held_q[1], held_q[2]);
  assign fl_new = flush_held(tk_cnt, tk_u, u_char_d, held_d[0], held_d[1], held_d[2]);

  // Step the escape state by one byte
  always_comb begin
    brk      = 1'b0;
    put      = 1'b0;
    put_byte = c;
    tk_cnt   = pend_cnt_q;
    tk_u     = pend_u_q;
    u_char_d = u_char_q;
    held_d   = held_q;
    tk_susp  = susp_q;
    case (pend_cnt_q)
      3'd0: begin
        if (c == ChPercent) begin
          tk_cnt = 3'd1;
          tk_u   = 1'b0;
        end else begin
          put = 1'b1;
        end
      end
      3'd1: begin
        if (c == ChLowerU || c == ChUpperU) begin
          tk_u     = 1'b1;
          u_char_d = c;
          tk_cnt   = 3'd2;
        end else if (is_hex(c)) begin
          held_d[0] = c;
          tk_cnt    = 3'd2;
        end else if (is_special(c)) begin
          put    = 1'b1;
          tk_cnt = 3'd0;
          tk_u   = 1'b0;
        end else begin
          brk = 1'b1;
        end
      end
      3'd2, 3'd3, 3'd4, 3'd5: begin
        if (!pend_u_q) begin
          if (is_hex(c)) begin
            put      = 1'b1;
            put_byte = hex_pair(held_q[0], c);
            tk_cnt   = 3'd0;
            tk_u     = 1'b0;
          end else begin
            brk = 1'b1;
          end
        end else if (pend_cnt_q == 3'd2) begin
          if (is_hex(c)) begin
            held_d[0] = c;
            tk_cnt    = 3'd3;
          end else if (is_special(c)) begin
            put    = 1'b1;
            tk_cnt = 3'd0;
            tk_u   = 1'b0;
          end else begin
            brk = 1'b1;
          end
        end else if (pend_cnt_q == 3'd3 || pend_cnt_q == 3'd4) begin
          if (is_hex(c)) begin
            if (pend_cnt_q == 3'd3) begin
              held_d[1] = c;
            end else begin
              held_d[2] = c;
            end
            tk_cnt = pend_cnt_q + 3'd1;
          end else begin
            brk = 1'b1;
          end
        end else begin
          if (is_hex(c)) begin
            if (held_q[0] == ChZero && held_q[1] == ChZero) begin
              put      = 1'b1;
              put_byte = hex_pair(held_q[2], c);
            end else begin
              tk_susp = 1'b1;
            end
            tk_cnt = 3'd0;
            tk_u   = 1'b0;
          end else begin
            brk = 1'b1;
          end
        end
      end
      default: begin
        // count of six or seven: drop the held bytes, handle c as idle
        tk_cnt = 3'd0;
        tk_u   = 1'b0;
        if (c == ChPercent) begin
          tk_cnt = 3'd1;
        end else begin
          put = 1'b1;
        end
      end
    endcase
    // A broken escape gives back its bytes, then c starts afresh
    if (brk) begin
      tk_cnt = 3'd0;
      tk_u   = 1'b0;
      if (c == ChPercent) begin
        tk_cnt = 3'd1;
      end else begin
        put = 1'b1;
      end
    end
  end

  // Assemble the result words in order
  always_comb begin
    n = '0;
    for (int i = 0; i < MaxWords; i++) begin
      em[i] = '0;
    end
    if (brk) begin
      for (int i = 0; i < MaxHeld; i++) begin
        if (CntW'(i) < fl_old.len) begin
          em[n] = fl_old.bytes[i];
          n     = n + CntW'(1);
        end
      end
    end
    if (put) begin
      em[n] = put_byte;
      n     = n + CntW'(1);
    end
    if (string_last_i) begin
      for (int i = 0; i < MaxHeld; i++) begin
        if (CntW'(i) < fl_new.len && n < CntW'(MaxWords)) begin
          em[n] = fl_new.bytes[i];
          n     = n + CntW'(1);
        end
      end
    end
  end

  assign load = in_acc && (n != '0 || string_last_i);

  // Next decoder state; string end returns it to idle
  always_comb begin
    pend_cnt_d = tk_cnt;
    pend_u_d   = tk_u;
    susp_d     = tk_susp;
    if (string_last_i) begin
      pend_cnt_d = 3'd0;
      pend_u_d   = 1'b0;
      susp_d     = 1'b0;
    end
  end

  // Hold configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_q     <= 1'b0;
      pend_cnt_q <= 3'd0;
      pend_u_q   <= 1'b0;
      u_char_q   <= '0;
      susp_q     <= 1'b0;
      buf_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        plus_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        pend_cnt_q <= pend_cnt_d;
        pend_u_q   <= pend_u_d;
        u_char_q   <= u_char_d;
        susp_q     <= susp_d;
      end
      if (load) begin
        buf_cnt_q <= (n == '0) ? CntW'(1) : n;
      end else if (out_acc) begin
        buf_cnt_q <= buf_cnt_q - CntW'(1);
      end
    end
  end

  // Load the result buffer or advance it by one word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      held_q <= held_d;
    end
    if (load) begin
      buf_q     <= em;
      buf_has_q <= n != '0;
      buf_end_q <= string_last_i;
      buf_sus_q <= tk_susp;
    end else if (out_acc) begin
      for (int i = 0; i < MaxWords - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  // Checks
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q <= 3'd5)
    else $error("escape hold count out of range");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && string_last_i |=> pend_cnt_q == 3'd0 && !susp_q)
    else $error("state not cleared after string end");

  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> string_end_o)
    else $error("empty word outside string end");

  a_sus_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && suspicious_o |-> string_end_o && run_last_o)
    else $error("suspicious flag outside string end");

endmodule

`default_nettype wire

@@ verif/url_percent_decoder_tb.sv @@
`timescale 1ns / 1ps

module url_percent_decoder_tb;

  import urlpd_pkg::*;

  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DrainCycles = 12;

  // One decoded output word as the port presents it
  typedef struct packed {
    logic [7:0] ch;
    logic       has_ch;
    logic       run_last;
    logic       str_end;
    logic       susp;
  } dec_word_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       has_byte_o;
  logic       run_last_o;
  logic       string_end_o;
  logic       suspicious_o;

  // Decoder state mirrored for prediction
  logic       plus_cfg;
  logic [2:0] pend_cnt;
  logic       pend_u;
  logic [7:0] u_ch;
  logic [7:0] held [3];
  logic       susp_seen;

  logic [7:0] emit_q [$];
  dec_word_t  decoded_q [$];
  logic [7:0] str_buf [$];
  logic [7:0] specials [6];

  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;
  int err_cnt;
  int n_bytes;
  int n_strings;
  int n_words;

  url_percent_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte),
    .string_last_i(in_last),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte_o),
    .has_byte_o   (has_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o),
    .suspicious_o (suspicious_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Character classes and hex values of the escape syntax
  function automatic logic is_hex_ch(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_special_ch(input logic [7:0] c);
    return c == ChSpace || c == ChQuote || c == ChPercent || c == ChAmp ||
           c == ChQuest || c == ChSlash;
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61) v = c - 8'h57;
    else v = c - 8'h37;
    return v[3:0];
  endfunction

  // Short gaps mostly, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] rand_hex_ch();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  task automatic drop_escape();
    pend_cnt = 3'd0;
    pend_u   = 1'b0;
  endtask

  // A byte seen with no escape open: '%' opens one, anything else passes
  task automatic take_plain(input logic [7:0] c);
    if (c == ChPercent) begin
      pend_cnt = 3'd1;
      pend_u   = 1'b0;
    end else begin
      emit_q.push_back(c);
    end
  endtask

  // Give back the bytes of an unfinished escape as they arrived
  task automatic give_back_held();
    if (pend_cnt >= 3'd1 && pend_cnt <= 3'd5) begin
      emit_q.push_back(ChPercent);
      if (pend_u) begin
        if (pend_cnt >= 3'd2) emit_q.push_back(u_ch);
        for (int i = 0; i + 3 <= int'(pend_cnt); i++) emit_q.push_back(held[i]);
      end else if (pend_cnt >= 3'd2) begin
        emit_q.push_back(held[0]);
      end
    end
    drop_escape();
  endtask

  task automatic break_escape(input logic [7:0] c);
    give_back_held();
    take_plain(c);
  endtask

  // Work out the output words of one accepted input byte
  task automatic predict_byte(input logic [7:0] raw, input logic last);
    logic [7:0] c;
    int         n;
    c = (plus_cfg && raw == ChPlus) ? ChSpace : raw;
    emit_q.delete();
    if (pend_cnt == 3'd0) begin
      take_plain(c);
    end else if (pend_cnt == 3'd1) begin
      if (c == ChLowerU || c == ChUpperU) begin
        pend_u   = 1'b1;
        u_ch     = c;
        pend_cnt = 3'd2;
      end else if (is_hex_ch(c)) begin
        held[0]  = c;
        pend_cnt = 3'd2;
      end else if (is_special_ch(c)) begin
        emit_q.push_back(c);
        drop_escape();
      end else begin
        break_escape(c);
      end
    end else if (pend_cnt > 3'd5) begin
      drop_escape();
      take_plain(c);
    end else if (!pend_u) begin
      if (is_hex_ch(c)) begin
        emit_q.push_back({nibble_of(held[0]), nibble_of(c)});
        drop_escape();
      end else begin
        break_escape(c);
      end
    end else if (pend_cnt == 3'd2) begin
      if (is_hex_ch(c)) begin
        held[0]  = c;
        pend_cnt = 3'd3;
      end else if (is_special_ch(c)) begin
        emit_q.push_back(c);
        drop_escape();
      end else begin
        break_escape(c);
      end
    end else if (pend_cnt < 3'd5) begin
      if (is_hex_ch(c)) begin
        held[pend_cnt - 3'd2] = c;
        pend_cnt = pend_cnt + 3'd1;
      end else begin
        break_escape(c);
      end
    end else begin
      // Fourth digit of a %u escape: only a zero high byte gives a character
      if (is_hex_ch(c)) begin
        if (held[0] == ChZero && held[1] == ChZero)
          emit_q.push_back({nibble_of(held[2]), nibble_of(c)});
        else
          susp_seen = 1'b1;
        drop_escape();
      end else begin
        break_escape(c);
      end
    end
    if (last) give_back_held();

    n = emit_q.size();
    if (n == 0 && last) begin
      decoded_q.push_back('{ch: 8'h00, has_ch: 1'b0, run_last: 1'b1, str_end: 1'b1,
                            susp: susp_seen});
    end else begin
      for (int k = 0; k < n; k++)
        decoded_q.push_back('{ch: emit_q[k], has_ch: 1'b1, run_last: (k == n - 1),
                              str_end: last && (k == n - 1),
                              susp: last && (k == n - 1) && susp_seen});
    end
    if (last) begin
      drop_escape();
      susp_seen = 1'b0;
      n_strings++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("mismatch at word %0d: %s got %0h want %0h", n_words, what, got, want);
  endtask

  // Offer one byte, hold it until taken, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_byte(b, last);
    n_bytes++;
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_buf();
    for (int i = 0; i < str_buf.size(); i++) send_byte(str_buf[i], i == str_buf.size() - 1);
  endtask

  task automatic send_text(input string s);
    str_buf.delete();
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
    send_buf();
  endtask

  // Pause the sender until every predicted word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_plus(input logic v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    plus_cfg = v;
  endtask

  // Append one random token: text, escapes, specials or a broken escape
  task automatic add_token();
    int kind;
    int k;
    kind = $urandom_range(0, 99);
    if (kind < 28) begin
      str_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 38) begin
      str_buf.push_back(ChPlus);
    end else if (kind < 53) begin
      str_buf.push_back(ChPercent);
      str_buf.push_back(rand_hex_ch());
      str_buf.push_back(rand_hex_ch());
    end else if (kind < 70) begin
      str_buf.push_back(ChPercent);
      str_buf.push_back(($urandom_range(0, 1) != 0) ? ChLowerU : ChUpperU);
      if ($urandom_range(0, 9) < 6) begin
        str_buf.push_back(ChZero);
        str_buf.push_back(ChZero);
      end else begin
        str_buf.push_back(rand_hex_ch());
        str_buf.push_back(rand_hex_ch());
      end
      str_buf.push_back(rand_hex_ch());
      str_buf.push_back(rand_hex_ch());
    end else if (kind < 78) begin
      str_buf.push_back(ChPercent);
      str_buf.push_back(specials[$urandom_range(0, 5)]);
    end else if (kind < 84) begin
      str_buf.push_back(ChPercent);
      str_buf.push_back(($urandom_range(0, 1) != 0) ? ChLowerU : ChUpperU);
      str_buf.push_back(specials[$urandom_range(0, 5)]);
    end else begin
      // Escape cut short by an arbitrary byte
      str_buf.push_back(ChPercent);
      if ($urandom_range(0, 1) != 0) begin
        str_buf.push_back(($urandom_range(0, 1) != 0) ? ChLowerU : ChUpperU);
        k = $urandom_range(0, 3);
      end else begin
        k = $urandom_range(0, 1);
      end
      repeat (k) str_buf.push_back(rand_hex_ch());
      str_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_strings(input int n_items);
    int sent;
    int n_tok;
    sent = 0;
    while (sent < n_items) begin
      str_buf.delete();
      n_tok = $urandom_range(1, 4);
      repeat (n_tok) add_token();
      sent += str_buf.size();
      send_buf();
    end
  endtask

  task automatic test_directed_escapes();
    write_plus(1'b0);
    send_text("%4a");
    send_text("%U00e9");
    // %u escape with a nonzero high byte: empty end word, flagged
    send_text("%u12Ab");
    send_text("%u/%&");
    // Broken escape, byte extremes, and a lone percent held at the end
    str_buf.delete();
    str_buf.push_back(ChPercent);
    str_buf.push_back(8'hFF);
    str_buf.push_back(8'h00);
    str_buf.push_back(ChPercent);
    send_buf();
    send_text("%u0G");
    send_text("%u12345x");
  endtask

  task automatic test_plus_mapping();
    send_text("+");
    write_plus(1'b1);
    send_text("+%+");
    write_plus(1'b0);
    send_text("a+");
  endtask

  task automatic test_random_traffic();
    write_plus(1'b0);
    run_random_strings(30);
    write_plus(1'b1);
    run_random_strings(25);
    // Stretch with both sides running flat out
    write_plus(1'($urandom_range(0, 1)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random_strings(20);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    write_plus(1'($urandom_range(0, 1)));
    run_random_strings(25);
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    run_random_strings(20);
    tx_idle_en = 1'b1;
    wait_drained();
  endtask

  // Receiver stall: random gaps, or a long hold on request
  initial begin : rx_stall_gen
    int left;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        left = pick_gap() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each output word taken with the oldest prediction
  always @(posedge clk_i) begin : word_check
    dec_word_t got;
    dec_word_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall) begin
      got = '{ch: out_byte_o, has_ch: has_byte_o, run_last: run_last_o,
              str_end: string_end_o, susp: suspicious_o};
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected word", got.ch, 8'h00);
      end else begin
        want = decoded_q.pop_front();
        if (got.ch !== want.ch) report_mismatch("out_byte", got.ch, want.ch);
        if (got.has_ch !== want.has_ch)
          report_mismatch("has_byte", 8'(got.has_ch), 8'(want.has_ch));
        if (got.run_last !== want.run_last)
          report_mismatch("run_last", 8'(got.run_last), 8'(want.run_last));
        if (got.str_end !== want.str_end)
          report_mismatch("string_end", 8'(got.str_end), 8'(want.str_end));
        if (got.susp !== want.susp)
          report_mismatch("suspicious", 8'(got.susp), 8'(want.susp));
      end
      n_words++;
    end
  end

  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    specials = '{ChSpace, ChQuote, ChPercent, ChAmp, ChQuest, ChSlash};
    plus_cfg   = 1'b0;
    pend_cnt   = 3'd0;
    pend_u     = 1'b0;
    u_ch       = 8'h00;
    held       = '{8'h00, 8'h00, 8'h00};
    susp_seen  = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req   = 1'b0;
    err_cnt    = 0;
    n_bytes    = 0;
    n_strings  = 0;
    n_words    = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_escapes();
    test_plus_mapping();
    test_random_traffic();
    test_output_backpressure();
    wait_drained();

    $display("Decoded %0d input bytes in %0d strings into %0d output words,",
             n_bytes, n_strings, n_words);
    $display("with hex and %%u escapes, specials, broken escapes and plus mapping.");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
